[hw/rtl/assert_macros.svh]
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define HRG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrg assertion failed");

// next-cycle implication, checked out of reset
`define HRG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrg assertion failed");

`endif

[hw/rtl/hrg_pkg.sv]
// types and constants of the heating relay gate
package hrg_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_MINUTES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REST_MINUTES = 3'd4;

  // configuration reset values
  localparam logic signed [10:0] FLOOR_LIMIT_RST = 11'sd350;
  localparam logic [7:0] HYSTERESIS_RST   = 8'd30;
  localparam logic [7:0] RUN_MINUTES_RST  = 8'd30;
  localparam logic [7:0] REST_MINUTES_RST = 8'd30;

  // start-up sequencer codes
  localparam logic [1:0] SU_INIT  = 2'd0;
  localparam logic [1:0] SU_DELAY = 2'd1;
  localparam logic [1:0] SU_RUN   = 2'd2;

  // duty timer codes
  localparam logic [1:0] DUTY_IDLE = 2'd0;
  localparam logic [1:0] DUTY_RUN  = 2'd1;
  localparam logic [1:0] DUTY_REST = 2'd2;

  // run modes
  localparam logic [1:0] MODE_NORMAL   = 2'd0;
  localparam logic [1:0] MODE_POWER_OFF = 2'd1;
  localparam logic [1:0] MODE_ADVANCED = 2'd2;
  localparam logic [1:0] MODE_TIMING   = 2'd3;

  typedef struct packed {
    logic signed [10:0] floor_limit_temp;
    logic [7:0]         limit_hysteresis;
    logic               duty_enable;
    logic [7:0]         run_minutes;
    logic [7:0]         rest_minutes;
  } cfg_t;

  typedef struct packed {
    logic signed [10:0] floor_temp;
    logic               all_sensor_mode;
    logic               system_error;
    logic               timing_ddr_on;
    logic [1:0]         run_mode;
    logic               heat_request;
    logic [15:0]        now_ms;
  } item_t;

  typedef struct packed {
    logic duty_resting;
    logic duty_active;
    logic over_limit;
    logic relay_on;
  } result_t;

  typedef struct packed {
    logic [1:0] startup_phase;
    logic [1:0] duty_phase;
  } status_t;

endpackage

[hw/rtl/hrg_cfg_regs.sv]
// configuration register file of the heating relay gate
module hrg_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [hrg_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [hrg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output hrg_pkg::cfg_t                    cfg
);

  hrg_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.floor_limit_temp <= hrg_pkg::FLOOR_LIMIT_RST;
      cfg_r.limit_hysteresis <= hrg_pkg::HYSTERESIS_RST;
      cfg_r.duty_enable      <= 1'b0;
      cfg_r.run_minutes      <= hrg_pkg::RUN_MINUTES_RST;
      cfg_r.rest_minutes     <= hrg_pkg::REST_MINUTES_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        hrg_pkg::REG_FLOOR_LIMIT:  cfg_r.floor_limit_temp <= $signed(cfg_wdata[10:0]);
        hrg_pkg::REG_HYSTERESIS:   cfg_r.limit_hysteresis <= cfg_wdata[7:0];
        hrg_pkg::REG_DUTY_ENABLE:  cfg_r.duty_enable      <= cfg_wdata[0];
        hrg_pkg::REG_RUN_MINUTES:  cfg_r.run_minutes      <= cfg_wdata[7:0];
        hrg_pkg::REG_REST_MINUTES: cfg_r.rest_minutes     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[hw/rtl/hrg_step.sv]
// gate state registers and the per-word update logic
module hrg_step #(
  parameter logic [15:0] MINUTE_MS        = 16'd60000,
  parameter logic [15:0] STARTUP_DELAY_MS = 16'd3000
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  hrg_pkg::item_t   item,
  input  hrg_pkg::cfg_t    cfg,
  output hrg_pkg::result_t result,
  output hrg_pkg::status_t status
);

  logic [1:0]  startup_phase_r, startup_phase_nxt;
  logic [15:0] startup_stamp_r, startup_stamp_nxt;
  logic        latch_r, latch_nxt;
  logic [1:0]  duty_phase_r, duty_phase_nxt;
  logic [15:0] minute_stamp_r, minute_stamp_nxt;
  logic [7:0]  minute_count_r, minute_count_nxt;
  logic        display_r, display_nxt;
  logic        relay_r, relay_nxt;

  logic               allowed;
  logic               flag;
  logic [15:0]        startup_passed;
  logic [15:0]        minute_passed;
  logic signed [11:0] clear_level;
  logic signed [11:0] temp_ext;
  logic [7:0]         period_len;
  logic [7:0]         count_inc;

  always_comb begin
    case (item.run_mode)
      hrg_pkg::MODE_NORMAL:    allowed = !item.system_error;
      hrg_pkg::MODE_POWER_OFF: allowed = 1'b0;
      hrg_pkg::MODE_ADVANCED:  allowed = 1'b0;
      hrg_pkg::MODE_TIMING:    allowed = !item.timing_ddr_on;
      default:                 allowed = 1'b0;
    endcase
  end

  assign startup_passed = item.now_ms - startup_stamp_r;
  assign minute_passed  = item.now_ms - minute_stamp_r;
  assign temp_ext       = {item.floor_temp[10], item.floor_temp};
  assign clear_level    = {cfg.floor_limit_temp[10], cfg.floor_limit_temp}
                          - $signed({4'b0000, cfg.limit_hysteresis});
  assign period_len     = (duty_phase_r == hrg_pkg::DUTY_REST) ? cfg.rest_minutes
                                                               : cfg.run_minutes;
  assign count_inc      = minute_count_r + 8'd1;

  always_comb begin
    startup_phase_nxt = startup_phase_r;
    startup_stamp_nxt = startup_stamp_r;
    latch_nxt         = latch_r;
    duty_phase_nxt    = duty_phase_r;
    minute_stamp_nxt  = minute_stamp_r;
    minute_count_nxt  = minute_count_r;
    display_nxt       = display_r;
    relay_nxt         = relay_r;
    flag              = 1'b0;

    case (startup_phase_r)
      hrg_pkg::SU_INIT: begin
        startup_stamp_nxt = item.now_ms;
        startup_phase_nxt = hrg_pkg::SU_DELAY;
      end
      hrg_pkg::SU_DELAY: begin
        if (startup_passed > STARTUP_DELAY_MS) begin
          startup_phase_nxt = hrg_pkg::SU_RUN;
        end
      end
      default: begin
        // over-limit latch only moves while the output is allowed
        if (allowed) begin
          if (!item.heat_request || !item.all_sensor_mode || item.system_error) begin
            latch_nxt = 1'b0;
          end else if (item.floor_temp >= cfg.floor_limit_temp) begin
            latch_nxt = 1'b1;
          end else if (temp_ext <= clear_level) begin
            latch_nxt = 1'b0;
          end
          flag = item.heat_request && !latch_nxt;
        end

        if (cfg.duty_enable && flag) begin
          if (duty_phase_r == hrg_pkg::DUTY_IDLE) begin
            minute_count_nxt = 8'd0;
            duty_phase_nxt   = hrg_pkg::DUTY_RUN;
            minute_stamp_nxt = item.now_ms;
            display_nxt      = 1'b1;
          end else if (minute_passed >= MINUTE_MS) begin
            minute_stamp_nxt = item.now_ms;
            minute_count_nxt = count_inc;
            if (count_inc >= period_len) begin
              minute_count_nxt = 8'd0;
              duty_phase_nxt   = (duty_phase_r == hrg_pkg::DUTY_REST) ? hrg_pkg::DUTY_RUN
                                                                      : hrg_pkg::DUTY_REST;
            end
          end
        end else begin
          minute_count_nxt = 8'd0;
          duty_phase_nxt   = hrg_pkg::DUTY_IDLE;
          minute_stamp_nxt = item.now_ms;
          display_nxt      = 1'b0;
        end

        relay_nxt = flag && (duty_phase_nxt != hrg_pkg::DUTY_REST);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      startup_phase_r <= hrg_pkg::SU_INIT;
      startup_stamp_r <= 16'd0;
      latch_r         <= 1'b0;
      duty_phase_r    <= hrg_pkg::DUTY_IDLE;
      minute_stamp_r  <= 16'd0;
      minute_count_r  <= 8'd0;
      display_r       <= 1'b0;
      relay_r         <= 1'b0;
    end else if (advance) begin
      startup_phase_r <= startup_phase_nxt;
      startup_stamp_r <= startup_stamp_nxt;
      latch_r         <= latch_nxt;
      duty_phase_r    <= duty_phase_nxt;
      minute_stamp_r  <= minute_stamp_nxt;
      minute_count_r  <= minute_count_nxt;
      display_r       <= display_nxt;
      relay_r         <= relay_nxt;
    end
  end

  assign result.relay_on     = relay_nxt;
  assign result.over_limit   = latch_nxt;
  assign result.duty_active  = display_nxt;
  assign result.duty_resting = (duty_phase_nxt == hrg_pkg::DUTY_REST);

  assign status.startup_phase = startup_phase_r;
  assign status.duty_phase    = duty_phase_r;

endmodule

[hw/rtl/heating_relay_gate_with_duty_timer_core.sv]
// top level of the heating relay gate with duty timer
//
//  channel   direction  handshake              payload
//  in_       slave      in_tvalid/in_tready    in_tdata, one scan word
//  out_      master     out_tvalid/out_tready  out_tdata, one result word per scan
//  cfg_      write      cfg_wr_en              cfg_addr, cfg_wdata
//
// a word passes through the input register and then the output register;
// one word per cycle is sustained while out_tready stays high.
// the state update sits between the two registers and fires when the input
// register holds a word and the output register is empty or being drained.
// a stall on out_ stops the update and, after one more word, in_tready.
// rst_n is synchronous; after it the start-up sequencer waits for the first word.
`include "assert_macros.svh"

module heating_relay_gate_with_duty_timer_core #(
  parameter logic [15:0] MINUTE_MS        = 16'd60000,
  parameter logic [15:0] STARTUP_DELAY_MS = 16'd3000
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // now_ms[15:0], heat_request[16], run_mode[18:17], timing_ddr_on[19],
  // system_error[20], all_sensor_mode[21], floor_temp[32:22], zero fill
  input  logic [hrg_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // relay_on[0], over_limit[1], duty_active[2], duty_resting[3], zero fill
  output logic [hrg_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_wr_en,
  input  logic [hrg_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [hrg_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  hrg_pkg::cfg_t    cfg;
  hrg_pkg::item_t   in_item_r;
  hrg_pkg::result_t result;
  hrg_pkg::status_t status;

  logic                              in_valid_r;
  logic                              out_valid_r;
  logic [hrg_pkg::OUT_DATA_W-1:0]    out_data_r;
  logic                              advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= in_tdata[32:0];
    end
    if (advance) begin
      out_data_r <= {4'b0000, result};
    end
  end

  hrg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hrg_step #(
    .MINUTE_MS        (MINUTE_MS),
    .STARTUP_DELAY_MS (STARTUP_DELAY_MS)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_item_r),
    .cfg     (cfg),
    .result  (result),
    .status  (status)
  );

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

  // the relay is never commanded during a rest period
  `HRG_ASSERT_NOW(a_no_relay_in_rest, out_tvalid && out_tdata[3], !out_tdata[0])
  // resting only happens once the duty timer is engaged
  `HRG_ASSERT_NOW(a_rest_needs_active, out_tvalid && out_tdata[3], out_tdata[2])
  // a relay command implies the start-up wait has finished
  `HRG_ASSERT_NOW(a_relay_after_startup, out_tvalid && out_tdata[0],
                  status.startup_phase == hrg_pkg::SU_RUN)
  // an empty output register never blocks the input side
  `HRG_ASSERT_NOW(a_ready_when_drained, !out_valid_r, in_tready)
  // the duty timer only ever sits in idle, run or rest
  `HRG_ASSERT_NOW(a_duty_phase_known, 1'b1, status.duty_phase <= hrg_pkg::DUTY_REST)

endmodule

[bench/hrg_scan_checker.sv]
// scoreboard for the heating relay gate: predicts every result word from the scans and compares
module hrg_scan_checker
  import hrg_pkg::*;
#(
  parameter logic [15:0] MINUTE_MS        = 16'd60000,
  parameter logic [15:0] STARTUP_DELAY_MS = 16'd3000
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the register file
  logic signed [10:0] floor_limit;
  logic [7:0]         hysteresis;
  logic               duty_on;
  logic [7:0]         run_len;
  logic [7:0]         rest_len;

  // predicted block state
  logic [1:0]  startup;
  logic [15:0] startup_at;
  logic        latch;
  logic [1:0]  duty_state;
  logic [15:0] minute_at;
  logic [7:0]  minutes;
  logic        duty_shown;
  logic        relay;

  result_t relay_words[$];

  function automatic result_t gate_scan(item_t w);
    result_t     r;
    logic        open;
    logic        flag;
    logic [15:0] gap;
    logic [7:0]  span;
    int          temp;
    int          clear_at;
    temp = int'(w.floor_temp);
    if (startup == SU_INIT) begin
      startup_at = w.now_ms;
      startup = SU_DELAY;
    end else if (startup == SU_DELAY) begin
      gap = w.now_ms - startup_at;
      if (gap > STARTUP_DELAY_MS) startup = SU_RUN;
    end else begin
      case (w.run_mode)
        MODE_NORMAL: open = !w.system_error;
        MODE_TIMING: open = !w.timing_ddr_on;
        default:     open = 1'b0;
      endcase
      flag = 1'b0;
      // a blocked output leaves the latch alone
      if (open) begin
        flag = w.heat_request;
        clear_at = int'(floor_limit) - int'(hysteresis);
        if (!flag || !w.all_sensor_mode || w.system_error) begin
          latch = 1'b0;
        end else if (temp >= int'(floor_limit)) begin
          latch = 1'b1;
        end else if (temp <= clear_at) begin
          latch = 1'b0;
        end
        if (latch) flag = 1'b0;
      end
      if (duty_on && flag) begin
        if (duty_state == DUTY_IDLE) begin
          minutes = 8'd0;
          duty_state = DUTY_RUN;
          minute_at = w.now_ms;
          duty_shown = 1'b1;
        end else begin
          gap = w.now_ms - minute_at;
          if (gap >= MINUTE_MS) begin
            span = (duty_state == DUTY_REST) ? rest_len : run_len;
            minute_at = w.now_ms;
            minutes = minutes + 8'd1;
            if (minutes >= span) begin
              minutes = 8'd0;
              duty_state = (duty_state == DUTY_REST) ? DUTY_RUN : DUTY_REST;
            end
          end
        end
      end else begin
        minutes = 8'd0;
        duty_state = DUTY_IDLE;
        minute_at = w.now_ms;
        duty_shown = 1'b0;
      end
      if (duty_state == DUTY_REST) flag = 1'b0;
      relay = flag;
    end
    r.relay_on = relay;
    r.over_limit = latch;
    r.duty_active = duty_shown;
    r.duty_resting = (duty_state == DUTY_REST);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      floor_limit = FLOOR_LIMIT_RST;
      hysteresis = HYSTERESIS_RST;
      duty_on = 1'b0;
      run_len = RUN_MINUTES_RST;
      rest_len = REST_MINUTES_RST;
      startup = SU_INIT;
      startup_at = '0;
      latch = 1'b0;
      duty_state = DUTY_IDLE;
      minute_at = '0;
      minutes = '0;
      duty_shown = 1'b0;
      relay = 1'b0;
      relay_words.delete();
      fail_count = 0;
      words_due <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_FLOOR_LIMIT:  floor_limit = cfg_wdata;
          REG_HYSTERESIS:   hysteresis = cfg_wdata[7:0];
          REG_DUTY_ENABLE:  duty_on = cfg_wdata[0];
          REG_RUN_MINUTES:  run_len = cfg_wdata[7:0];
          REG_REST_MINUTES: rest_len = cfg_wdata[7:0];
          default: ;
        endcase
      end
      // the result leaving now belongs to an older scan, so retire before adding
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(result_t)-1:0];
        if (relay_words.size() == 0) begin
          $error("result word %h arrived with no scan waiting", out_tdata);
          fail_count++;
        end else begin
          want = relay_words.pop_front();
          if (got.relay_on !== want.relay_on) begin
            $error("relay_on: expected %0b, got %0b", want.relay_on, got.relay_on);
            fail_count++;
          end
          if (got.over_limit !== want.over_limit) begin
            $error("over_limit: expected %0b, got %0b", want.over_limit, got.over_limit);
            fail_count++;
          end
          if (got.duty_active !== want.duty_active) begin
            $error("duty_active: expected %0b, got %0b", want.duty_active, got.duty_active);
            fail_count++;
          end
          if (got.duty_resting !== want.duty_resting) begin
            $error("duty_resting: expected %0b, got %0b", want.duty_resting,
                   got.duty_resting);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) relay_words.push_back(gate_scan(in_tdata[$bits(item_t)-1:0]));
      words_due <= relay_words.size();
    end
  end

endmodule

[bench/tb.sv]
// testbench top for the heating relay gate: drives scans and register settings, reports verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hrg_pkg::*;

  localparam logic [15:0] MINUTE_MS        = 16'd60000;
  localparam logic [15:0] STARTUP_DELAY_MS = 16'd3000;
  localparam int RANDOM_SCANS = 1550;
  localparam int PHASES       = 8;
  localparam int PHASE_SCANS  = RANDOM_SCANS / PHASES;
  localparam int CYCLE_LIMIT  = 400000;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    fail_count;
  int                    words_due;

  bit          calm = 1'b0;
  bit          gaps_on = 1'b1;
  logic [15:0] clock_ms = '0;
  int          cycles = 0;

  heating_relay_gate_with_duty_timer_core #(
    .MINUTE_MS(MINUTE_MS),
    .STARTUP_DELAY_MS(STARTUP_DELAY_MS)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  hrg_scan_checker #(
    .MINUTE_MS(MINUTE_MS),
    .STARTUP_DELAY_MS(STARTUP_DELAY_MS)
  ) scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .words_due(words_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // result side back-pressure
  initial begin
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, ($urandom_range(0, 5) == 0) ? 60 : 10)) @(posedge clk);
    end
  end

  task automatic send_scan(input item_t w);
    in_tdata <= {{(IN_DATA_W - $bits(item_t)){1'b0}}, w};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic scan_item(input logic [15:0] now, input logic req, input logic [1:0] mode,
                           input logic ddr, input logic err, input logic sens, input int temp);
    item_t w;
    w.now_ms = now;
    w.heat_request = req;
    w.run_mode = mode;
    w.timing_ddr_on = ddr;
    w.system_error = err;
    w.all_sensor_mode = sens;
    w.floor_temp = 11'(temp);
    send_scan(w);
  endtask

  // registers only change once every scan in flight has its result back
  task automatic configure(input cfg_t c);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    cfg_wr_en <= 1'b1;
    cfg_addr <= REG_FLOOR_LIMIT;
    cfg_wdata <= c.floor_limit_temp;
    @(posedge clk);
    cfg_addr <= REG_HYSTERESIS;
    cfg_wdata <= CFG_DATA_W'(c.limit_hysteresis);
    @(posedge clk);
    cfg_addr <= REG_DUTY_ENABLE;
    cfg_wdata <= CFG_DATA_W'(c.duty_enable);
    @(posedge clk);
    cfg_addr <= REG_RUN_MINUTES;
    cfg_wdata <= CFG_DATA_W'(c.run_minutes);
    @(posedge clk);
    cfg_addr <= REG_REST_MINUTES;
    cfg_wdata <= CFG_DATA_W'(c.rest_minutes);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [15:0] advance_ms();
    case ($urandom_range(0, 9))
      0:       clock_ms = clock_ms;
      1:       clock_ms = clock_ms + 16'($urandom_range(55000, 65535));
      default: clock_ms = clock_ms + 16'($urandom_range(1, 20000));
    endcase
    return clock_ms;
  endfunction

  function automatic int clamp_temp(int t);
    if (t < -1024) return -1024;
    if (t > 1023) return 1023;
    return t;
  endfunction

  // steady demand so the duty timer and the latch get past their first states
  task automatic run_stretch(input cfg_t c, input int count);
    logic       sens;
    logic [1:0] mode;
    int         lo;
    int         temp;
    sens = 1'($urandom_range(0, 1));
    lo = int'(c.floor_limit_temp) - int'(c.limit_hysteresis);
    for (int k = 0; k < count; k++) begin
      mode = ($urandom_range(0, 9) < 7) ? MODE_NORMAL : MODE_TIMING;
      if ($urandom_range(0, 6) != 0) temp = lo - int'($urandom_range(1, 60));
      else temp = lo - 10 + int'($urandom_range(0, int'(c.limit_hysteresis) + 30));
      if (mode == MODE_NORMAL)
        scan_item(advance_ms(), 1'b1, mode, 1'($urandom_range(0, 1)), 1'b0, sens,
                  clamp_temp(temp));
      else
        scan_item(advance_ms(), 1'b1, mode, 1'b0, 1'($urandom_range(0, 1)), sens,
                  clamp_temp(temp));
    end
  endtask

  task automatic send_noise(input int count);
    logic [63:0] bits;
    item_t       w;
    for (int k = 0; k < count; k++) begin
      bits = {$urandom, $urandom};
      w = bits[$bits(item_t)-1:0];
      w.now_ms = advance_ms();
      send_scan(w);
    end
  endtask

  initial begin
    cfg_t setting;
    int   done;
    int   n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // start-up: stamp taken, then the delay must be exceeded across the wrap
    scan_item(16'd65000, 1'b1, MODE_NORMAL, 1'b0, 1'b0, 1'b0, 0);
    scan_item(16'd2464, 1'b1, MODE_NORMAL, 1'b0, 1'b0, 1'b0, 0);
    scan_item(16'd2465, 1'b1, MODE_NORMAL, 1'b0, 1'b0, 1'b0, 0);
    // output gating by mode and error
    scan_item(16'd65535, 1'b1, MODE_NORMAL, 1'b0, 1'b0, 1'b0, 0);
    scan_item(16'd0, 1'b1, MODE_POWER_OFF, 1'b0, 1'b0, 1'b0, 0);
    scan_item(16'd1, 1'b1, MODE_ADVANCED, 1'b0, 1'b0, 1'b0, 0);
    scan_item(16'd2, 1'b1, MODE_TIMING, 1'b1, 1'b0, 1'b0, 0);
    scan_item(16'd3, 1'b1, MODE_TIMING, 1'b0, 1'b1, 1'b0, 0);
    scan_item(16'd4, 1'b1, MODE_NORMAL, 1'b0, 1'b1, 1'b0, 0);
    scan_item(16'd5, 1'b0, MODE_NORMAL, 1'b0, 1'b0, 1'b0, 0);
    // over-limit latch: set at the limit, hold in the band, hold while blocked, clear at the band floor
    scan_item(16'd6, 1'b1, MODE_NORMAL, 1'b0, 1'b0, 1'b1, 350);
    scan_item(16'd7, 1'b1, MODE_NORMAL, 1'b0, 1'b0, 1'b1, 335);
    scan_item(16'd8, 1'b1, MODE_POWER_OFF, 1'b0, 1'b0, 1'b1, -1024);
    scan_item(16'd9, 1'b1, MODE_NORMAL, 1'b0, 1'b0, 1'b1, 320);
    scan_item(16'd10, 1'b1, MODE_NORMAL, 1'b0, 1'b0, 1'b1, 1023);
    scan_item(16'd11, 1'b1, MODE_NORMAL, 1'b0, 1'b0, 1'b0, 1023);
    scan_item(16'd12, 1'b1, MODE_NORMAL, 1'b0, 1'b0, 1'b1, 1023);
    scan_item(16'd13, 1'b0, MODE_NORMAL, 1'b0, 1'b0, 1'b1, 1023);
    scan_item(16'd14, 1'b1, MODE_NORMAL, 1'b0, 1'b0, 1'b1, 1023);
    scan_item(16'd15, 1'b1, MODE_TIMING, 1'b0, 1'b1, 1'b1, 1023);

    // duty timer: zero-minute run period, one-minute rest across the wrap, drop of demand
    setting = '{FLOOR_LIMIT_RST, HYSTERESIS_RST, 1'b1, 8'd0, 8'd1};
    configure(setting);
    scan_item(16'd1000, 1'b1, MODE_NORMAL, 1'b0, 1'b0, 1'b0, 0);
    scan_item(16'd61000, 1'b1, MODE_NORMAL, 1'b0, 1'b0, 1'b0, 0);
    scan_item(16'd62000, 1'b1, MODE_NORMAL, 1'b0, 1'b0, 1'b0, 0);
    scan_item(16'd56464, 1'b1, MODE_NORMAL, 1'b0, 1'b0, 1'b0, 0);
    scan_item(16'd56465, 1'b0, MODE_NORMAL, 1'b0, 1'b0, 1'b0, 0);
    scan_item(16'd56466, 1'b1, MODE_NORMAL, 1'b0, 1'b0, 1'b0, 0);
    clock_ms = 16'd56466;

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: setting = '{FLOOR_LIMIT_RST, HYSTERESIS_RST, 1'b0, RUN_MINUTES_RST, REST_MINUTES_RST};
        1: setting = '{11'sh400, 8'd255, 1'b1, 8'd0, 8'd0};
        2: setting = '{11'sh3ff, 8'd0, 1'b1, 8'd255, 8'd255};
        default: begin
          setting.floor_limit_temp = 11'($urandom_range(0, 2047));
          setting.limit_hysteresis = 8'($urandom_range(0, 255));
          setting.duty_enable = ($urandom_range(0, 3) != 0);
          setting.run_minutes = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                            : 8'($urandom_range(0, 3));
          setting.rest_minutes = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                             : 8'($urandom_range(0, 3));
        end
      endcase
      configure(setting);
      gaps_on = (ph % 3 != 2);
      done = 0;
      while (done < PHASE_SCANS) begin
        if (ph == PHASES - 1 && done >= PHASE_SCANS / 3) calm = 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          n = $urandom_range(1, 3);
          send_noise(n);
        end else begin
          n = $urandom_range(5, 40);
          run_stretch(setting, n);
        end
        done += n;
      end
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
